@@ design/rfsc_pkg.sv @@
// ============================================================================
// rfsc_pkg - shared types and constants of the remote frame sync block
// Register indexes, fixed sync bytes, reset values and status types.
// ============================================================================
package rfsc_pkg;

    // Configuration register indexes
    localparam logic [7:0] REG_HEAD = 8'd0;
    localparam logic [7:0] REG_TAIL = 8'd1;

    // Reset values of the configuration registers
    localparam logic [7:0] HEAD_RESET = 8'hA5;
    localparam logic [7:0] TAIL_RESET = 8'h5A;

    // Fixed sync bytes that follow the head byte
    localparam logic [7:0] SYNC_0 = 8'h97;
    localparam logic [7:0] SYNC_1 = 8'h98;
    localparam logic [7:0] SYNC_2 = 8'h0A;
    localparam logic [7:0] SYNC_3 = 8'hC1;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int KEY_IDX_W = 5;
    localparam int CFG_IDX_W = 8;

    // Queue status seen by the front part and the checks
    typedef struct packed {
        logic full;
        logic empty;
    } rfsc_qstat_t;

endpackage

@@ design/rfsc_if.sv @@
// ============================================================================
// rfsc_if - channel interfaces
// Byte input channel, key output channel and configuration write channel.
// ============================================================================

// Received byte stream
interface rfsc_byte_if;
    logic                            valid;
    logic                            ready;
    logic [rfsc_pkg::BYTE_W-1:0]     byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

// Key bytes of accepted frames
interface rfsc_key_if;
    logic                            valid;
    logic                            ready;
    logic [rfsc_pkg::BYTE_W-1:0]     key_byte;
    logic [rfsc_pkg::KEY_IDX_W-1:0]  key_index;
    logic                            last_key;

    modport source (output valid, output key_byte, output key_index, output last_key,
                    input ready);
    modport sink   (input valid, input key_byte, input key_index, input last_key,
                    output ready);
endinterface

// Configuration register writes
interface rfsc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rfsc_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [rfsc_pkg::BYTE_W-1:0]     wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

@@ design/rfsc_front.sv @@
// ============================================================================
// rfsc_front - byte window and frame detection
// Keeps the sliding window, its fill count and running sum, holds the head
// and tail registers, and pushes the key bytes of each valid frame.
// ============================================================================
module rfsc_front #(
    parameter int KEY_COUNT = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    rfsc_byte_if.sink                  byte_ch,
    rfsc_cfg_if.sink                   cfg_ch,
    input  rfsc_pkg::rfsc_qstat_t      qstat,
    output logic                       push,
    output logic [KEY_COUNT*8-1:0]     push_data,
    output logic                       frame_hit
);
    localparam int WIN       = KEY_COUNT + 6;
    localparam int FILL_W    = $clog2(WIN + 1);
    localparam int WIN_IDX_W = $clog2(WIN);

    logic [7:0]        head_reg, tail_reg;
    logic [7:0]        win_reg  [WIN];
    logic [7:0]        win_next [WIN];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]        sum_reg, sum_next;
    logic              full;
    logic              accept;
    logic [7:0]        check_sum;
    logic [7:0]        b;

    // Configuration registers, always ready
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= rfsc_pkg::HEAD_RESET;
            tail_reg <= rfsc_pkg::TAIL_RESET;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.reg_index)
                rfsc_pkg::REG_HEAD: head_reg <= cfg_ch.wdata;
                rfsc_pkg::REG_TAIL: tail_reg <= cfg_ch.wdata;
                default: ;
            endcase
        end
    end

    // Input handshake: stall only when the queue has no room
    assign byte_ch.ready = !qstat.full;
    assign accept        = byte_ch.valid && byte_ch.ready;
    assign b             = byte_ch.byte_in;

    // Frame check: sum of all window bytes but the checksum slot
    assign full      = (fill_reg == FILL_W'(WIN));
    assign check_sum = sum_reg - win_reg[WIN-1];
    assign frame_hit = full
                    && (win_reg[0] == head_reg)
                    && (win_reg[1] == rfsc_pkg::SYNC_0)
                    && (win_reg[2] == rfsc_pkg::SYNC_1)
                    && (win_reg[3] == rfsc_pkg::SYNC_2)
                    && (win_reg[4] == rfsc_pkg::SYNC_3)
                    && (win_reg[WIN-1] == check_sum)
                    && (b == tail_reg);

    assign push = accept && frame_hit;

    // Key bytes, first key in the low byte
    always_comb
    begin
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            push_data[k*8 +: 8] = win_reg[5+k];
        end
    end

    // Window update: append, slide, or empty on a frame
    always_comb
    begin
        win_next  = win_reg;
        fill_next = fill_reg;
        sum_next  = sum_reg;
        if (accept)
        begin
            if (!full)
            begin
                win_next[fill_reg[WIN_IDX_W-1:0]] = b;
                fill_next = fill_reg + FILL_W'(1);
                sum_next  = sum_reg + b;
            end
            else if (frame_hit)
            begin
                fill_next = '0;
                sum_next  = '0;
            end
            else
            begin
                for (int i = 0; i < WIN - 1; i++)
                begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[WIN-1] = b;
                sum_next = sum_reg - win_reg[0] + b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            sum_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
        end
    end

    // Window bytes are payload; the fill count qualifies them
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

@@ design/rfsc_queue.sv @@
// ============================================================================
// rfsc_queue - two-entry frame queue
// Holds the key bytes of detected frames between detection and emission.
// ============================================================================
module rfsc_queue #(
    parameter int DATA_W = 80
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [DATA_W-1:0]     push_data,
    input  logic                  pop,
    output logic [DATA_W-1:0]     pop_data,
    output rfsc_pkg::rfsc_qstat_t qstat
);
    logic [DATA_W-1:0] mem [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;

    assign qstat.full  = (count_reg == 2'd2);
    assign qstat.empty = (count_reg == 2'd0);
    assign pop_data    = mem[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/rfsc_back.sv @@
// ============================================================================
// rfsc_back - key byte emitter
// Takes one frame from the queue and sends its key bytes one per request.
// ============================================================================
module rfsc_back #(
    parameter int KEY_COUNT = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rfsc_pkg::rfsc_qstat_t  qstat,
    input  logic [KEY_COUNT*8-1:0] pop_data,
    output logic                   pop,
    rfsc_key_if.source             key_ch
);
    localparam int IW = rfsc_pkg::KEY_IDX_W;

    logic                   busy_reg, busy_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic [KEY_COUNT*8-1:0] data_reg, data_next;
    logic                   fire;
    logic                   last;

    assign last             = (idx_reg == IW'(KEY_COUNT - 1));
    assign fire             = key_ch.valid && key_ch.ready;
    assign key_ch.valid     = busy_reg;
    assign key_ch.key_byte  = data_reg[7:0];
    assign key_ch.key_index = idx_reg;
    assign key_ch.last_key  = last;

    // Load a new frame when idle or when the last key leaves
    assign pop = !qstat.empty && (!busy_reg || (fire && last));

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        data_next = data_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            data_next = pop_data;
        end
        else if (fire)
        begin
            data_next = data_reg >> 8;
            idx_next  = idx_reg + IW'(1);
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

@@ design/remote_frame_sync_checksum.sv @@
// ============================================================================
// remote_frame_sync_checksum - remote control frame sync with sum checksum
// Finds head/sync/keys/checksum/tail frames in a byte stream and sends out
// the key bytes of each valid frame.
// ============================================================================
//  channel   dir  payload                          handshake
//  byte_ch   in   byte_in[7:0]                     valid/ready
//  cfg_ch    in   reg_index[7:0], wdata[7:0]       valid/ready (always ready)
//  key_ch    out  key_byte, key_index, last_key    valid/ready
//
//  One byte is accepted per cycle while the queue has room; the frame check on it is combinational.
//  A valid frame yields KEY_COUNT key bytes, one per cycle from the emitter while key_ch is ready.
//  byte_ch stalls only while both entries of the frame queue are occupied.
//  Reset empties the window, the queue and the emitter, and restores
//  head 0xA5 and tail 0x5A.
// ============================================================================
module remote_frame_sync_checksum #(
    parameter int KEY_COUNT = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    rfsc_byte_if.sink   byte_ch,
    rfsc_cfg_if.sink    cfg_ch,
    rfsc_key_if.source  key_ch
);
    logic                   push;
    logic [KEY_COUNT*8-1:0] push_data;
    logic                   pop;
    logic [KEY_COUNT*8-1:0] pop_data;
    logic                   frame_hit;
    rfsc_pkg::rfsc_qstat_t  qstat;

    rfsc_front #(.KEY_COUNT(KEY_COUNT)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .cfg_ch    (cfg_ch),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data),
        .frame_hit (frame_hit)
    );

    rfsc_queue #(.DATA_W(KEY_COUNT*8)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    rfsc_back #(.KEY_COUNT(KEY_COUNT)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .qstat    (qstat),
        .pop_data (pop_data),
        .pop      (pop),
        .key_ch   (key_ch)
    );

    // A frame keeps sending until its last key byte
    a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (key_ch.valid && key_ch.ready && !key_ch.last_key) |=> key_ch.valid)
        else $error("key stream broke off before the last key");

    // Each emitted frame starts at key index zero
    a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(key_ch.valid) |-> (key_ch.key_index == '0))
        else $error("frame did not start at key index zero");

    // A detected frame is never pushed into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("frame pushed into a full queue");

    // An accepted byte that completes a frame is always queued
    a_push_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_hit && byte_ch.valid && byte_ch.ready) |-> push)
        else $error("detected frame was not queued");

    // Queue status is consistent
    a_qstat: assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue reported full and empty");

endmodule
